// ===== sv/rc4_pkg.sv =====
// Package with the shared types, constants and register codes of the RC4 cipher block.
`default_nettype none

package rc4_pkg;

   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned KEY_BYTES = 32;
   localparam int unsigned SBOX_DEPTH = 256;

   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned KEY_LEN_WIDTH = 6;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 64;
   localparam int unsigned KEY_POS_WIDTH = $clog2(KEY_BYTES);

   localparam logic [KEY_LEN_WIDTH-1:0] KEY_LEN_RESET = 6'd16;
   localparam logic [KEY_LEN_WIDTH-1:0] KEY_LEN_MAX = KEY_LEN_WIDTH'(KEY_BYTES);
   localparam logic [KEY_LEN_WIDTH-1:0] KEY_LEN_MIN = 6'd1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD3 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LENGTH = 3'd4;

   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [7:0][BYTE_WIDTH-1:0] key_word_type;
   typedef key_word_type [KEY_WORDS-1:0] key_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_RD_N,
      ST_KS_RD_J,
      ST_KS_WR_N,
      ST_KS_WR_J,
      ST_PR_RD_I,
      ST_PR_RD_J,
      ST_PR_WR_I,
      ST_PR_WR_J,
      ST_PR_RD_K,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/rc4_if.sv =====
// Request and response channel interfaces of the RC4 cipher block.
`default_nettype none

interface rc4_req_if;
   logic              valid;
   logic              ready;
   rc4_pkg::byte_type data_byte;
   logic              first;

   modport source (output valid, output data_byte, output first, input ready);
   modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface rc4_rsp_if;
   logic              valid;
   logic              ready;
   rc4_pkg::byte_type out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/rc4_stream_cipher.sv =====
// RC4 stream cipher: one data byte in, the byte XORed with the next keystream byte out.
//
// The permutation lives in a single-port 256 x 8 synchronous memory. A keyed byte needs
// five accesses (read S[i], read S[j], write S[i], write S[j], read the keystream entry)
// plus a final step to register the result. No new request is taken while a byte is in
// progress; the next request is taken in the cycle the current result is loaded. A
// request with first set, and every request until the first key schedule has finished
// after reset, reloads all 256 permutation entries and runs the key schedule (4 accesses
// for each of 256 steps) before its byte. The key words and key length are read
// throughout a key schedule and should only be written while the block is idle. A key
// length of zero uses one byte; lengths above 32 use 32.
`default_nettype none

module rc4_stream_cipher (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   rc4_req_if.sink                                     req_bus,
   rc4_rsp_if.source                                   rsp_bus,
   input  wire logic                                   csr_write_enable,
   input  wire logic [rc4_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [rc4_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   localparam int unsigned AddrWidth = $clog2(rc4_pkg::SBOX_DEPTH);

   rc4_pkg::state_type state_ff, state_in;

   rc4_pkg::key_type                        key_ff;
   logic [rc4_pkg::KEY_LEN_WIDTH-1:0]       key_len_ff;
   logic [rc4_pkg::KEY_LEN_WIDTH-1:0]       used_len;

   logic                                    keyed_ff;
   logic [AddrWidth-1:0]                    i_ff;
   logic [AddrWidth-1:0]                    j_ff;
   logic [AddrWidth-1:0]                    n_ff;
   logic [AddrWidth-1:0]                    kj_ff;
   logic [rc4_pkg::KEY_POS_WIDTH-1:0]       kp_ff;
   logic [rc4_pkg::KEY_POS_WIDTH-1:0]       kp_in;
   rc4_pkg::byte_type                       swap_a_ff;
   rc4_pkg::byte_type                       swap_b_ff;
   rc4_pkg::byte_type                       data_ff;
   rc4_pkg::byte_type                       out_ff;
   logic                                    rsp_valid_ff;

   rc4_pkg::byte_type                       sbox_mem [rc4_pkg::SBOX_DEPTH];
   rc4_pkg::byte_type                       sbox_rdata_ff;
   logic [AddrWidth-1:0]                    mem_addr;
   rc4_pkg::byte_type                       mem_wdata;
   logic                                    mem_we;
   logic                                    mem_re;

   logic                                    accept;
   logic                                    rekey;
   logic                                    out_load;
   logic                                    ks_last;
   rc4_pkg::byte_type                       key_byte;
   logic [AddrWidth-1:0]                    ks_j_sum;
   logic [AddrWidth-1:0]                    pr_j_sum;
   logic [AddrWidth-1:0]                    ks_addr;

   // Handshake and datapath helpers.
   assign out_load = (state_ff == rc4_pkg::ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = (state_ff == rc4_pkg::ST_IDLE) || out_load;
   assign accept = req_bus.valid && req_bus.ready;
   assign rekey = req_bus.first || !keyed_ff;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_byte = out_ff;

   assign ks_last = (n_ff == AddrWidth'(rc4_pkg::SBOX_DEPTH - 1));
   assign key_byte = key_ff[kp_ff[rc4_pkg::KEY_POS_WIDTH-1:3]][kp_ff[2:0]];
   assign ks_j_sum = kj_ff + sbox_rdata_ff + key_byte;
   assign pr_j_sum = j_ff + sbox_rdata_ff;
   assign ks_addr = swap_a_ff + swap_b_ff;

   always_comb begin
      if (key_len_ff == '0) begin
         used_len = rc4_pkg::KEY_LEN_MIN;
      end else if (key_len_ff > rc4_pkg::KEY_LEN_MAX) begin
         used_len = rc4_pkg::KEY_LEN_MAX;
      end else begin
         used_len = key_len_ff;
      end
   end

   always_comb begin
      if (({1'b0, kp_ff} + 6'd1) >= used_len) begin
         kp_in = '0;
      end else begin
         kp_in = kp_ff + 1'b1;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         key_len_ff <= rc4_pkg::KEY_LEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rc4_pkg::CSR_KEY_WORD0: key_ff[0] <= csr_write_data;
            rc4_pkg::CSR_KEY_WORD1: key_ff[1] <= csr_write_data;
            rc4_pkg::CSR_KEY_WORD2: key_ff[2] <= csr_write_data;
            rc4_pkg::CSR_KEY_WORD3: key_ff[3] <= csr_write_data;
            rc4_pkg::CSR_KEY_LENGTH: key_len_ff <= csr_write_data[rc4_pkg::KEY_LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = rekey ? rc4_pkg::ST_INIT : rc4_pkg::ST_PR_RD_I;
            end
         end
         rc4_pkg::ST_INIT: begin
            if (ks_last) begin
               state_in = rc4_pkg::ST_KS_RD_N;
            end
         end
         rc4_pkg::ST_KS_RD_N: state_in = rc4_pkg::ST_KS_RD_J;
         rc4_pkg::ST_KS_RD_J: state_in = rc4_pkg::ST_KS_WR_N;
         rc4_pkg::ST_KS_WR_N: state_in = rc4_pkg::ST_KS_WR_J;
         rc4_pkg::ST_KS_WR_J: state_in = ks_last ? rc4_pkg::ST_PR_RD_I : rc4_pkg::ST_KS_RD_N;
         rc4_pkg::ST_PR_RD_I: state_in = rc4_pkg::ST_PR_RD_J;
         rc4_pkg::ST_PR_RD_J: state_in = rc4_pkg::ST_PR_WR_I;
         rc4_pkg::ST_PR_WR_I: state_in = rc4_pkg::ST_PR_WR_J;
         rc4_pkg::ST_PR_WR_J: state_in = rc4_pkg::ST_PR_RD_K;
         rc4_pkg::ST_PR_RD_K: state_in = rc4_pkg::ST_OUT;
         rc4_pkg::ST_OUT: begin
            if (out_load) begin
               if (accept) begin
                  state_in = rekey ? rc4_pkg::ST_INIT : rc4_pkg::ST_PR_RD_I;
               end else begin
                  state_in = rc4_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = rc4_pkg::ST_IDLE;
      endcase
   end

   // Memory access decode.
   always_comb begin
      mem_addr = n_ff;
      mem_wdata = sbox_rdata_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      unique case (state_ff)
         rc4_pkg::ST_INIT: begin
            mem_addr = n_ff;
            mem_wdata = n_ff;
            mem_we = 1'b1;
         end
         rc4_pkg::ST_KS_RD_N: begin
            mem_addr = n_ff;
            mem_re = 1'b1;
         end
         rc4_pkg::ST_KS_RD_J: begin
            mem_addr = ks_j_sum;
            mem_re = 1'b1;
         end
         rc4_pkg::ST_KS_WR_N: begin
            mem_addr = n_ff;
            mem_wdata = sbox_rdata_ff;
            mem_we = 1'b1;
         end
         rc4_pkg::ST_KS_WR_J: begin
            mem_addr = kj_ff;
            mem_wdata = swap_a_ff;
            mem_we = 1'b1;
         end
         rc4_pkg::ST_PR_RD_I: begin
            mem_addr = i_ff;
            mem_re = 1'b1;
         end
         rc4_pkg::ST_PR_RD_J: begin
            mem_addr = pr_j_sum;
            mem_re = 1'b1;
         end
         rc4_pkg::ST_PR_WR_I: begin
            mem_addr = i_ff;
            mem_wdata = sbox_rdata_ff;
            mem_we = 1'b1;
         end
         rc4_pkg::ST_PR_WR_J: begin
            mem_addr = j_ff;
            mem_wdata = swap_a_ff;
            mem_we = 1'b1;
         end
         rc4_pkg::ST_PR_RD_K: begin
            mem_addr = ks_addr;
            mem_re = 1'b1;
         end
         default: ;
      endcase
   end

   // Permutation memory. Read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sbox_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         sbox_rdata_ff <= sbox_mem[mem_addr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rc4_pkg::ST_IDLE;
         keyed_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && !rekey) begin
            i_ff <= i_ff + 1'b1;
         end
         if (state_ff == rc4_pkg::ST_KS_WR_J && ks_last) begin
            // The schedule leaves both indices at zero; the first byte then uses i = 1.
            i_ff <= AddrWidth'(1);
            j_ff <= '0;
            keyed_ff <= 1'b1;
         end
         if (state_ff == rc4_pkg::ST_PR_RD_J) begin
            j_ff <= pr_j_sum;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_bus.data_byte;
         n_ff <= '0;
         kj_ff <= '0;
         kp_ff <= '0;
      end
      if (state_ff == rc4_pkg::ST_INIT) begin
         n_ff <= n_ff + 1'b1;
      end
      if (state_ff == rc4_pkg::ST_KS_RD_J) begin
         swap_a_ff <= sbox_rdata_ff;
         kj_ff <= ks_j_sum;
      end
      if (state_ff == rc4_pkg::ST_KS_WR_J) begin
         n_ff <= n_ff + 1'b1;
         kp_ff <= kp_in;
      end
      if (state_ff == rc4_pkg::ST_PR_RD_J) begin
         swap_a_ff <= sbox_rdata_ff;
      end
      if (state_ff == rc4_pkg::ST_PR_WR_I) begin
         swap_b_ff <= sbox_rdata_ff;
      end
      if (out_load) begin
         out_ff <= data_ff ^ sbox_rdata_ff;
      end
   end

   // A request is never taken while a byte or a key schedule is in progress.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != rc4_pkg::ST_IDLE && state_ff != rc4_pkg::ST_OUT) |-> !req_bus.ready)
      else $error("request taken while busy");

   // A new result only appears after the keystream read has completed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rc4_pkg::ST_OUT))
      else $error("result raised outside the output step");

   // A request that must rekey starts the permutation reload.
   assert property (@(posedge clock) disable iff (reset)
      (accept && rekey) |=> (state_ff == rc4_pkg::ST_INIT && n_ff == '0))
      else $error("rekey request did not start the key schedule");

   // The end of the key schedule leaves the indices ready for the first byte.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4_pkg::ST_KS_WR_J && ks_last)
         |=> (i_ff == AddrWidth'(1) && j_ff == '0 && keyed_ff))
      else $error("indices wrong after key schedule");

   // The single-port memory never sees a read and a write in the same cycle.
   assert property (@(posedge clock) disable iff (reset) !(mem_we && mem_re))
      else $error("memory read and write collide");

endmodule

`default_nettype wire

// ===== tb/rc4_stream_cipher_tb.sv =====
// Self-checking testbench for the RC4 stream cipher: known vectors, then random messages.
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;

   typedef logic [rc4_pkg::CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [rc4_pkg::KEY_LEN_WIDTH-1:0] key_len_type;

   localparam int unsigned RANDOM_REQUESTS = 1000;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned CALM_PERIOD = 400;
   localparam csr_index_type CSR_UNUSED_LO = csr_index_type'(rc4_pkg::CSR_KEY_LENGTH + 1);
   localparam csr_index_type CSR_UNUSED_HI = '1;

   typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      csr_index_type                        index;
      logic [rc4_pkg::CSR_DATA_WIDTH-1:0]   value;
      rc4_pkg::byte_type                    data;
      logic                                 first;
      logic                                 known;
      rc4_pkg::byte_type                    answer;
   } stimulus_row_type;

   // Known vectors: key "Key" with "Plaintext", key "Wiki" with "pedia".
   localparam stimulus_row_type DIRECTED [38] = '{
      '{ROW_WRITE, rc4_pkg::CSR_KEY_WORD0, 64'h0000_0000_0079_654B, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, rc4_pkg::CSR_KEY_LENGTH, 64'h0000_0000_0000_0003, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h50, 1'b0, 1'b1, 8'hBB},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h6C, 1'b0, 1'b1, 8'hF3},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h61, 1'b0, 1'b1, 8'h16},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h69, 1'b0, 1'b1, 8'hE8},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h6E, 1'b0, 1'b1, 8'hD9},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h74, 1'b0, 1'b1, 8'h40},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h65, 1'b0, 1'b1, 8'hAF},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h78, 1'b0, 1'b1, 8'h0A},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h74, 1'b0, 1'b1, 8'hD3},
      '{ROW_WRITE, rc4_pkg::CSR_KEY_WORD0, 64'h0000_0000_696B_6957, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, rc4_pkg::CSR_KEY_LENGTH, 64'h0000_0000_0000_0004, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h70, 1'b1, 1'b1, 8'h10},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h65, 1'b0, 1'b1, 8'h21},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h64, 1'b0, 1'b1, 8'hBF},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h69, 1'b0, 1'b1, 8'h04},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h61, 1'b0, 1'b1, 8'h20},
      '{ROW_WRITE, rc4_pkg::CSR_KEY_WORD0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, rc4_pkg::CSR_KEY_WORD1, 64'h5555_5555_5555_5555, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, rc4_pkg::CSR_KEY_WORD2, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, rc4_pkg::CSR_KEY_WORD3, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, 8'h00},
      // A length of 63 saturates to the full 32 key bytes.
      '{ROW_WRITE, rc4_pkg::CSR_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'hFF, 1'b1, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, rc4_pkg::CSR_KEY_LENGTH, 64'h0000_0000_0000_0020, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h00, 1'b1, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'hFF, 1'b0, 1'b0, 8'h00},
      // A length of zero uses key byte 0 alone.
      '{ROW_WRITE, rc4_pkg::CSR_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'hA5, 1'b1, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h5A, 1'b0, 1'b0, 8'h00},
      // A key change inside a message only matters at the next rekey.
      '{ROW_WRITE, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h3C, 1'b0, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'hC3, 1'b1, 1'b0, 8'h00},
      '{ROW_WRITE, CSR_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, CSR_UNUSED_HI, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'h0F, 1'b1, 1'b0, 8'h00},
      '{ROW_REQUEST, rc4_pkg::CSR_KEY_WORD0, 64'h0, 8'hF0, 1'b0, 1'b0, 8'h00}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   csr_index_type csr_index;
   logic [rc4_pkg::CSR_DATA_WIDTH-1:0] csr_write_data;

   rc4_req_if req_bus ();
   rc4_rsp_if rsp_bus ();

   rc4_stream_cipher dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Mirror of the cipher state and key registers.
   rc4_pkg::byte_type cipher_sbox [rc4_pkg::SBOX_DEPTH];
   rc4_pkg::byte_type cipher_i;
   rc4_pkg::byte_type cipher_j;
   logic cipher_keyed;
   rc4_pkg::key_type key_mirror;
   key_len_type key_len_mirror;

   rc4_pkg::byte_type expected_bytes [$];
   int unsigned error_count = 0;
   bit sender_calm = 1'b0;
   bit receiver_calm;
   int unsigned rsp_stall_left;
   int unsigned calm_timer;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned random_gap(input bit calm);
      int unsigned roll;
      if (calm)
         return 0;
      roll = $urandom_range(99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic rc4_pkg::byte_type predict_cipher_byte(input rc4_pkg::byte_type data,
                                                              input logic first);
      int unsigned key_len;
      int unsigned k;
      rc4_pkg::byte_type sched_j;
      rc4_pkg::byte_type swap;
      rc4_pkg::byte_type keystream;
      if (first || !cipher_keyed) begin
         if (key_len_mirror == 0)
            key_len = 1;
         else if (key_len_mirror > rc4_pkg::KEY_BYTES)
            key_len = rc4_pkg::KEY_BYTES;
         else
            key_len = key_len_mirror;
         for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++)
            cipher_sbox[n] = rc4_pkg::byte_type'(n);
         sched_j = '0;
         for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++) begin
            k = n % key_len;
            sched_j = rc4_pkg::byte_type'(sched_j + cipher_sbox[n] + key_mirror[k / 8][k % 8]);
            swap = cipher_sbox[n];
            cipher_sbox[n] = cipher_sbox[sched_j];
            cipher_sbox[sched_j] = swap;
         end
         cipher_i = '0;
         cipher_j = '0;
         cipher_keyed = 1'b1;
      end
      cipher_i = rc4_pkg::byte_type'(cipher_i + 1);
      cipher_j = rc4_pkg::byte_type'(cipher_j + cipher_sbox[cipher_i]);
      swap = cipher_sbox[cipher_i];
      cipher_sbox[cipher_i] = cipher_sbox[cipher_j];
      cipher_sbox[cipher_j] = swap;
      keystream = cipher_sbox[rc4_pkg::byte_type'(cipher_sbox[cipher_i] + cipher_sbox[cipher_j])];
      return data ^ keystream;
   endfunction

   // Leaves the write enable high; the next request lowers it.
   task automatic csr_write(input csr_index_type index,
                            input logic [rc4_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      if (index == rc4_pkg::CSR_KEY_LENGTH)
         key_len_mirror = value[rc4_pkg::KEY_LEN_WIDTH-1:0];
      else if (index < rc4_pkg::CSR_KEY_LENGTH)
         key_mirror[index] = value;
      @(posedge clock);
   endtask

   task automatic send_request(input rc4_pkg::byte_type data, input logic first,
                               input logic known, input rc4_pkg::byte_type answer);
      rc4_pkg::byte_type predicted;
      int unsigned gap;
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.first <= first;
      csr_write_enable <= 1'b0;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = predict_cipher_byte(data, first);
      expected_bytes.push_back(known ? answer : predicted);
      gap = random_gap(sender_calm);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Always waits on the clock before returning, so valid is never lowered and raised in one step.
   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_bytes.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left <= 0;
         receiver_calm <= 1'b0;
         calm_timer <= CALM_PERIOD;
      end else begin
         if (calm_timer == 0) begin
            receiver_calm <= ($urandom_range(3) == 0);
            calm_timer <= CALM_PERIOD;
         end else begin
            calm_timer <= calm_timer - 1;
         end
         if (rsp_stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall_left <= rsp_stall_left - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_stall_left <= random_gap(receiver_calm);
         end
      end
   end

   always @(posedge clock) begin
      rc4_pkg::byte_type wanted;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte: response with no request pending, actual 0x%02h",
                   rsp_bus.out_byte);
            error_count++;
         end else begin
            wanted = expected_bytes.pop_front();
            if (rsp_bus.out_byte !== wanted) begin
               $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                      wanted, rsp_bus.out_byte);
               error_count++;
            end
         end
      end
   end

   initial begin
      #150ms;
      $display("FAIL rc4_stream_cipher");
      $finish;
   end

   initial begin
      bit writing;
      int unsigned sent;
      int unsigned burst;
      logic opening_first;
      logic [rc4_pkg::CSR_DATA_WIDTH-1:0] word;
      int unsigned style;

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.first = 1'b0;
      key_mirror = '0;
      key_len_mirror = rc4_pkg::KEY_LEN_RESET;
      cipher_i = '0;
      cipher_j = '0;
      cipher_keyed = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      writing = 1'b0;
      for (int r = 0; r < $size(DIRECTED); r++) begin
         if (DIRECTED[r].kind == ROW_WRITE) begin
            if (!writing)
               wait_for_idle();
            csr_write(DIRECTED[r].index, DIRECTED[r].value);
            writing = 1'b1;
         end else begin
            send_request(DIRECTED[r].data, DIRECTED[r].first, DIRECTED[r].known,
                         DIRECTED[r].answer);
            writing = 1'b0;
         end
      end

      // Random messages; the key may change between them with or without a rekey.
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         wait_for_idle();
         for (int w = rc4_pkg::CSR_KEY_WORD0; w <= rc4_pkg::CSR_KEY_WORD3; w++) begin
            if ($urandom_range(1) == 0) begin
               style = $urandom_range(7);
               if (style == 0)
                  word = '0;
               else if (style == 1)
                  word = '1;
               else
                  word = {$urandom, $urandom};
               csr_write(csr_index_type'(w), word);
            end
         end
         if ($urandom_range(1) == 0) begin
            word = {$urandom, $urandom};
            if ($urandom_range(3) != 0)
               word[rc4_pkg::KEY_LEN_WIDTH-1:0] =
                  key_len_type'($urandom_range(rc4_pkg::KEY_BYTES, 1));
            csr_write(rc4_pkg::CSR_KEY_LENGTH, word);
         end
         if ($urandom_range(7) == 0)
            csr_write(csr_index_type'($urandom_range(CSR_UNUSED_HI, CSR_UNUSED_LO)),
                      {$urandom, $urandom});
         sender_calm = ($urandom_range(3) == 0);
         burst = $urandom_range(80, 10);
         opening_first = ($urandom_range(9) < 7);
         for (int n = 0; n < burst; n++) begin
            if ($urandom_range(49) == 0)
               wait_for_idle();
            send_request(rc4_pkg::byte_type'($urandom_range(255)),
                         (n == 0) ? opening_first : ($urandom_range(49) == 0), 1'b0, '0);
         end
         sent += burst;
      end

      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0)
         $display("PASS rc4_stream_cipher");
      else
         $display("FAIL rc4_stream_cipher");
      $finish;
   end

endmodule
